// ----- rtl/core/assert_macros.svh -----
// Shared assertion shorthands, clocked on the rising edge and off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/ppid_pkg.sv -----
package ppid_pkg;

    localparam int DATA_W                = 16;
    localparam int GAIN_W                = 16;
    localparam int ERR_W                 = 17;
    localparam int DIFF_W                = 18;
    localparam int GAIN_FRAC_BITS        = 8;
    localparam int INTEGRAL_WIDTH_DEFAULT = 40;
    localparam int REG_INDEX_W           = 3;

    localparam logic signed [GAIN_W-1:0] GAIN_P_RESET  = 16'sd256;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RESET  = 16'sd0;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RESET  = 16'sd0;
    localparam logic signed [DATA_W-1:0] SETPOINT_RESET = 16'sd0;
    localparam logic signed [DATA_W-1:0] OUT_MIN_RESET  = 16'sh8000;
    localparam logic signed [DATA_W-1:0] OUT_MAX_RESET  = 16'sh7FFF;

    typedef enum logic [REG_INDEX_W-1:0] {
        REG_GAIN_P   = 3'd0,
        REG_GAIN_I   = 3'd1,
        REG_GAIN_D   = 3'd2,
        REG_SETPOINT = 3'd3,
        REG_OUT_MIN  = 3'd4,
        REG_OUT_MAX  = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic signed [DATA_W-1:0] setpoint;
        logic signed [DATA_W-1:0] out_min;
        logic signed [DATA_W-1:0] out_max;
    } cfg_t;

    // Setpoint write: clear the integral and reload the error history.
    typedef struct packed {
        logic                     clear;
        logic signed [DATA_W-1:0] value;
    } hist_t;

endpackage

// ----- rtl/core/ppid_cfg_regs.sv -----
module ppid_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [ppid_pkg::REG_INDEX_W-1:0]     cfg_index,
    input  logic [ppid_pkg::DATA_W-1:0]          cfg_data,
    output ppid_pkg::cfg_t                       cfg,
    output ppid_pkg::hist_t                      hist
);

    ppid_pkg::cfg_t cfg_reg;
    ppid_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (ppid_pkg::reg_index_t'(cfg_index))
                ppid_pkg::REG_GAIN_P:   cfg_next.gain_p   = cfg_data;
                ppid_pkg::REG_GAIN_I:   cfg_next.gain_i   = cfg_data;
                ppid_pkg::REG_GAIN_D:   cfg_next.gain_d   = cfg_data;
                ppid_pkg::REG_SETPOINT: cfg_next.setpoint = cfg_data;
                ppid_pkg::REG_OUT_MIN:  cfg_next.out_min  = cfg_data;
                ppid_pkg::REG_OUT_MAX:  cfg_next.out_max  = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p   <= ppid_pkg::GAIN_P_RESET;
            cfg_reg.gain_i   <= ppid_pkg::GAIN_I_RESET;
            cfg_reg.gain_d   <= ppid_pkg::GAIN_D_RESET;
            cfg_reg.setpoint <= ppid_pkg::SETPOINT_RESET;
            cfg_reg.out_min  <= ppid_pkg::OUT_MIN_RESET;
            cfg_reg.out_max  <= ppid_pkg::OUT_MAX_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg        = cfg_reg;
    assign hist.clear = cfg_write && (cfg_index == ppid_pkg::REG_SETPOINT);
    assign hist.value = cfg_data;

endmodule

// ----- rtl/core/ppid_state_stage.sv -----
`include "assert_macros.svh"

module ppid_state_stage #(
    parameter int INTEGRAL_WIDTH = ppid_pkg::INTEGRAL_WIDTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ppid_pkg::cfg_t                        cfg,
    input  ppid_pkg::hist_t                       hist,
    input  logic                                  up_valid,
    output logic                                  up_ready,
    input  logic signed [ppid_pkg::DATA_W-1:0]    measurement,
    output logic                                  dn_valid,
    input  logic                                  dn_ready,
    output logic signed [ppid_pkg::ERR_W-1:0]     err_out,
    output logic signed [ppid_pkg::DIFF_W-1:0]    diff_out,
    output logic signed [INTEGRAL_WIDTH-1:0]      integral_out
);

    localparam logic signed [INTEGRAL_WIDTH-1:0] INT_MAX = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
    localparam logic signed [INTEGRAL_WIDTH-1:0] INT_MIN = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};

    logic                                  valid_reg;
    logic signed [ppid_pkg::ERR_W-1:0]     err_reg;
    logic signed [ppid_pkg::DIFF_W-1:0]    diff_reg;
    logic signed [INTEGRAL_WIDTH-1:0]      integral_reg;
    logic signed [INTEGRAL_WIDTH-1:0]      integral_next;
    logic signed [ppid_pkg::ERR_W-1:0]     prev_error_reg;
    logic signed [ppid_pkg::ERR_W-1:0]     prev_error_next;
    logic signed [ppid_pkg::ERR_W-1:0]     err;
    logic signed [ppid_pkg::DIFF_W-1:0]    diff;
    logic        [INTEGRAL_WIDTH:0]        int_sum;
    logic signed [INTEGRAL_WIDTH-1:0]      int_sat;
    logic                                  load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    assign err  = {cfg.setpoint[ppid_pkg::DATA_W-1], cfg.setpoint}
                - {measurement[ppid_pkg::DATA_W-1], measurement};
    assign diff = {err[ppid_pkg::ERR_W-1], err}
                - {prev_error_reg[ppid_pkg::ERR_W-1], prev_error_reg};

    // Saturating accumulate: one guard bit flags overflow.
    assign int_sum = {integral_reg[INTEGRAL_WIDTH-1], integral_reg}
                   + (INTEGRAL_WIDTH+1)'(err);

    always_comb
    begin
        if (int_sum[INTEGRAL_WIDTH] != int_sum[INTEGRAL_WIDTH-1])
        begin
            int_sat = int_sum[INTEGRAL_WIDTH] ? INT_MIN : INT_MAX;
        end
        else
        begin
            int_sat = int_sum[INTEGRAL_WIDTH-1:0];
        end
    end

    // A setpoint write wins over a transfer in the same cycle.
    always_comb
    begin
        integral_next   = integral_reg;
        prev_error_next = prev_error_reg;
        if (hist.clear)
        begin
            integral_next   = '0;
            prev_error_next = ppid_pkg::ERR_W'(hist.value);
        end
        else if (load)
        begin
            integral_next   = int_sat;
            prev_error_next = err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            integral_reg   <= '0;
            prev_error_reg <= '0;
        end
        else
        begin
            integral_reg   <= integral_next;
            prev_error_reg <= prev_error_next;
            if (up_ready)
            begin
                valid_reg <= up_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            err_reg  <= err;
            diff_reg <= diff;
        end
    end

    assign dn_valid     = valid_reg;
    assign err_out      = err_reg;
    assign diff_out     = diff_reg;
    assign integral_out = integral_reg;

    `ASSERT_NEXT(a_hist_clear_zeroes_integral, clk, rst_n, hist.clear, integral_reg == '0)

endmodule

// ----- rtl/core/ppid_mult_stage.sv -----
module ppid_mult_stage #(
    parameter int INTEGRAL_WIDTH = ppid_pkg::INTEGRAL_WIDTH_DEFAULT
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  ppid_pkg::cfg_t                                cfg,
    input  logic                                          up_valid,
    output logic                                          up_ready,
    input  logic signed [ppid_pkg::ERR_W-1:0]             err_in,
    input  logic signed [ppid_pkg::DIFF_W-1:0]            diff_in,
    input  logic signed [INTEGRAL_WIDTH-1:0]              integral_in,
    output logic                                          dn_valid,
    input  logic                                          dn_ready,
    output logic signed [ppid_pkg::ERR_W-1:0]             err_out,
    output logic signed [ppid_pkg::GAIN_W+ppid_pkg::ERR_W-1:0]  prod_p,
    output logic signed [ppid_pkg::GAIN_W+ppid_pkg::DIFF_W-1:0] prod_d,
    output logic signed [ppid_pkg::GAIN_W+INTEGRAL_WIDTH/2:0]   prod_ilo,
    output logic signed [ppid_pkg::GAIN_W+INTEGRAL_WIDTH-INTEGRAL_WIDTH/2-1:0] prod_ihi
);

    localparam int ILO = INTEGRAL_WIDTH / 2;
    localparam int IHI = INTEGRAL_WIDTH - ILO;
    localparam int PW  = ppid_pkg::GAIN_W + ppid_pkg::ERR_W;
    localparam int DW  = ppid_pkg::GAIN_W + ppid_pkg::DIFF_W;
    localparam int LW  = ppid_pkg::GAIN_W + ILO + 1;
    localparam int HW  = ppid_pkg::GAIN_W + IHI;

    logic                                 valid_reg;
    logic signed [ppid_pkg::ERR_W-1:0]    err_reg;
    logic signed [PW-1:0]                 prod_p_reg;
    logic signed [DW-1:0]                 prod_d_reg;
    logic signed [LW-1:0]                 prod_ilo_reg;
    logic signed [HW-1:0]                 prod_ihi_reg;
    logic signed [PW-1:0]                 prod_p_next;
    logic signed [DW-1:0]                 prod_d_next;
    logic signed [LW-1:0]                 prod_ilo_next;
    logic signed [HW-1:0]                 prod_ihi_next;
    logic signed [ILO:0]                  int_lo;
    logic signed [IHI-1:0]                int_hi;
    logic                                 load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    // Split the integral so each product stays narrow; low half unsigned.
    assign int_lo = {1'b0, integral_in[ILO-1:0]};
    assign int_hi = integral_in[INTEGRAL_WIDTH-1:ILO];

    assign prod_p_next   = cfg.gain_p * err_in;
    assign prod_d_next   = cfg.gain_d * diff_in;
    assign prod_ilo_next = cfg.gain_i * int_lo;
    assign prod_ihi_next = cfg.gain_i * int_hi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            err_reg      <= err_in;
            prod_p_reg   <= prod_p_next;
            prod_d_reg   <= prod_d_next;
            prod_ilo_reg <= prod_ilo_next;
            prod_ihi_reg <= prod_ihi_next;
        end
    end

    assign dn_valid = valid_reg;
    assign err_out  = err_reg;
    assign prod_p   = prod_p_reg;
    assign prod_d   = prod_d_reg;
    assign prod_ilo = prod_ilo_reg;
    assign prod_ihi = prod_ihi_reg;

endmodule

// ----- rtl/core/ppid_out_stage.sv -----
`include "assert_macros.svh"

module ppid_out_stage #(
    parameter int INTEGRAL_WIDTH = ppid_pkg::INTEGRAL_WIDTH_DEFAULT
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  ppid_pkg::cfg_t                                cfg,
    input  logic                                          up_valid,
    output logic                                          up_ready,
    input  logic signed [ppid_pkg::ERR_W-1:0]             err_in,
    input  logic signed [ppid_pkg::GAIN_W+ppid_pkg::ERR_W-1:0]  prod_p,
    input  logic signed [ppid_pkg::GAIN_W+ppid_pkg::DIFF_W-1:0] prod_d,
    input  logic signed [ppid_pkg::GAIN_W+INTEGRAL_WIDTH/2:0]   prod_ilo,
    input  logic signed [ppid_pkg::GAIN_W+INTEGRAL_WIDTH-INTEGRAL_WIDTH/2-1:0] prod_ihi,
    output logic                                          dn_valid,
    input  logic                                          dn_ready,
    output logic signed [ppid_pkg::DATA_W-1:0]            drive,
    output logic signed [ppid_pkg::ERR_W-1:0]             current_error
);

    localparam int ILO   = INTEGRAL_WIDTH / 2;
    localparam int SUM_W = INTEGRAL_WIDTH + ppid_pkg::DIFF_W;
    localparam int SH_W  = SUM_W - ppid_pkg::GAIN_FRAC_BITS;

    logic                                 valid_reg;
    logic signed [ppid_pkg::DATA_W-1:0]   drive_reg;
    logic signed [ppid_pkg::DATA_W-1:0]   drive_next;
    logic signed [ppid_pkg::ERR_W-1:0]    err_reg;
    logic signed [SUM_W-1:0]              sum;
    logic signed [SUM_W-1:0]              sum_shr;
    logic signed [SH_W-1:0]               scaled;
    logic signed [SH_W-1:0]               lim_max;
    logic signed [SH_W-1:0]               lim_min;
    logic                                 load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    assign sum = SUM_W'(prod_p) + SUM_W'(prod_d) + SUM_W'(prod_ilo)
               + (SUM_W'(prod_ihi) <<< ILO);

    // Arithmetic shift floors toward minus infinity.
    assign sum_shr = sum >>> ppid_pkg::GAIN_FRAC_BITS;
    assign scaled  = sum_shr[SH_W-1:0];
    assign lim_max = SH_W'(cfg.out_max);
    assign lim_min = SH_W'(cfg.out_min);

    // Lower clamp first, upper clamp second: inverted limits give out_min.
    always_comb
    begin
        if ((scaled < lim_min) || (lim_max < lim_min))
        begin
            drive_next = cfg.out_min;
        end
        else if (scaled > lim_max)
        begin
            drive_next = cfg.out_max;
        end
        else
        begin
            drive_next = scaled[ppid_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_reg <= drive_next;
            err_reg   <= err_in;
        end
    end

    assign dn_valid      = valid_reg;
    assign drive         = drive_reg;
    assign current_error = err_reg;

    `ASSERT_NEXT(a_drive_within_limits, clk, rst_n, load && (cfg.out_min <= cfg.out_max), (drive_reg >= $past(cfg.out_min)) && (drive_reg <= $past(cfg.out_max)))

endmodule

// ----- rtl/core/positional_pid_controller_unit.sv -----
// Positional PID controller with output clamp.
//
// Input channel: one measurement per transfer (in_valid high, in_stall low).
// Output channel: drive and current_error per transfer (out_valid high,
// out_stall low). Exactly one result leaves for every measurement taken.
// Configuration: cfg_write with cfg_index/cfg_data writes one register
// (0 gain_p, 1 gain_i, 2 gain_d, 3 setpoint, 4 out_min, 5 out_max);
// other indexes are dropped. Write only while the pipeline is empty.
// A setpoint write clears the integral and loads the error history.
//
// Throughput: one item per cycle while in_stall is low, set by the
// error/integral update, a 17-bit subtract and a saturating integral
// add that close in the accept cycle. Products are registered in stage
// two; the sum, shift and clamp fill stage three. Each stage holds its
// own valid bit, so bubbles collapse and a new measurement is taken
// while a finished result waits.
// Reset: config, integral and error history return to their reset values,
// the pipeline empties. A stalled receiver holds the output; in_stall
// rises only when all three stages are full and out_stall is high.

`include "assert_macros.svh"

module positional_pid_controller_unit #(
    parameter int INTEGRAL_WIDTH = ppid_pkg::INTEGRAL_WIDTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [ppid_pkg::REG_INDEX_W-1:0]      cfg_index,
    input  logic [ppid_pkg::DATA_W-1:0]           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [ppid_pkg::DATA_W-1:0]    measurement,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [ppid_pkg::DATA_W-1:0]    drive,
    output logic signed [ppid_pkg::ERR_W-1:0]     current_error
);

    localparam int ILO = INTEGRAL_WIDTH / 2;
    localparam int IHI = INTEGRAL_WIDTH - ILO;

    ppid_pkg::cfg_t                                   cfg;
    ppid_pkg::hist_t                                  hist;
    logic                                             in_ready;
    logic                                             s1_valid;
    logic                                             s1_ready;
    logic signed [ppid_pkg::ERR_W-1:0]                s1_err;
    logic signed [ppid_pkg::DIFF_W-1:0]               s1_diff;
    logic signed [INTEGRAL_WIDTH-1:0]                 s1_integral;
    logic                                             s2_valid;
    logic                                             s2_ready;
    logic signed [ppid_pkg::ERR_W-1:0]                s2_err;
    logic signed [ppid_pkg::GAIN_W+ppid_pkg::ERR_W-1:0]  s2_prod_p;
    logic signed [ppid_pkg::GAIN_W+ppid_pkg::DIFF_W-1:0] s2_prod_d;
    logic signed [ppid_pkg::GAIN_W+ILO:0]             s2_prod_ilo;
    logic signed [ppid_pkg::GAIN_W+IHI-1:0]           s2_prod_ihi;

    ppid_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .hist      (hist)
    );

    // Stage one: error, derivative difference, integral update.
    ppid_state_stage #(
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_state (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .hist         (hist),
        .up_valid     (in_valid),
        .up_ready     (in_ready),
        .measurement  (measurement),
        .dn_valid     (s1_valid),
        .dn_ready     (s1_ready),
        .err_out      (s1_err),
        .diff_out     (s1_diff),
        .integral_out (s1_integral)
    );

    // Stage two: gain products, integral term split in two halves.
    ppid_mult_stage #(
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_mult (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .up_valid    (s1_valid),
        .up_ready    (s1_ready),
        .err_in      (s1_err),
        .diff_in     (s1_diff),
        .integral_in (s1_integral),
        .dn_valid    (s2_valid),
        .dn_ready    (s2_ready),
        .err_out     (s2_err),
        .prod_p      (s2_prod_p),
        .prod_d      (s2_prod_d),
        .prod_ilo    (s2_prod_ilo),
        .prod_ihi    (s2_prod_ihi)
    );

    // Stage three: sum, scale, clamp into the result register.
    ppid_out_stage #(
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .up_valid      (s2_valid),
        .up_ready      (s2_ready),
        .err_in        (s2_err),
        .prod_p        (s2_prod_p),
        .prod_d        (s2_prod_d),
        .prod_ilo      (s2_prod_ilo),
        .prod_ihi      (s2_prod_ihi),
        .dn_valid      (out_valid),
        .dn_ready      (!out_stall),
        .drive         (drive),
        .current_error (current_error)
    );

    assign in_stall = !in_ready;

    `ASSERT_IMPLIES(a_stall_only_when_full, clk, rst_n, in_stall, s1_valid && s2_valid && out_valid && out_stall)

endmodule

// ----- dv/positional_pid_controller_unit_tb.sv -----
module positional_pid_controller_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Run the block at its default integral width. A full-scale windup burst
    // then moves the integral far from zero without reaching either limit.
    localparam int INTEG_W        = ppid_pkg::INTEGRAL_WIDTH_DEFAULT;
    localparam int RANDOM_ITEMS   = 850;
    localparam int SETTLE_CYCLES  = 6;     // pipeline is 3 deep, leave margin
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all

    // Indexes the block has no register for; writes to them must be dropped.
    localparam logic [ppid_pkg::REG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [ppid_pkg::REG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;
    typedef enum logic [1:0] {PH_TRACK, PH_NOISE, PH_WINDUP} phase_kind_t;

    // One row of the directed table. For a write, idx/value are the register
    // and its data; for an item, value is the measurement and, when typed is
    // set, exp_drive/exp_err hold the result worked out by hand.
    typedef struct packed {
        row_kind_t                         kind;
        logic [ppid_pkg::REG_INDEX_W-1:0]  idx;
        logic [ppid_pkg::DATA_W-1:0]       value;
        logic                              typed;
        logic [ppid_pkg::DATA_W-1:0]       exp_drive;
        logic [ppid_pkg::ERR_W-1:0]        exp_err;
    } dir_row_t;

    typedef struct packed {
        logic signed [ppid_pkg::DATA_W-1:0] drive_val;
        logic signed [ppid_pkg::ERR_W-1:0]  error_val;
    } ctl_out_t;

    localparam int DIR_ROWS = 33;

    dir_row_t dir_tab [DIR_ROWS] = '{
        // Reset settings: unit P gain, no I or D, full-range clamp.
        '{ROW_ITEM,  '0,                     16'sd0,     1'b1, 16'sd0,      17'sd0},
        '{ROW_ITEM,  '0,                     16'sd32767, 1'b1, -16'sd32767, -17'sd32767},
        '{ROW_ITEM,  '0,                     16'sh8000,  1'b1, 16'sd32767,  17'sd32768},
        '{ROW_ITEM,  '0,                     16'sd100,   1'b1, -16'sd100,   -17'sd100},
        // Bring in integral and derivative terms.
        '{ROW_WRITE, ppid_pkg::REG_GAIN_I,   16'sd128,   1'b0, '0, '0},
        '{ROW_WRITE, ppid_pkg::REG_GAIN_D,   -16'sd256,  1'b0, '0, '0},
        '{ROW_ITEM,  '0,                     16'sd50,    1'b0, '0, '0},
        '{ROW_ITEM,  '0,                     -16'sd50,   1'b0, '0, '0},
        '{ROW_ITEM,  '0,                     16'sd1234,  1'b0, '0, '0},
        // New target: integral cleared, history loaded with the target.
        '{ROW_WRITE, ppid_pkg::REG_SETPOINT, 16'sd1000,  1'b0, '0, '0},
        '{ROW_ITEM,  '0,                     16'sd1000,  1'b0, '0, '0},
        '{ROW_ITEM,  '0,                     16'sd900,   1'b0, '0, '0},
        // Inverted limits: the lower clamp wins, drive is always out_min.
        '{ROW_WRITE, ppid_pkg::REG_OUT_MIN,  16'sd100,   1'b0, '0, '0},
        '{ROW_WRITE, ppid_pkg::REG_OUT_MAX,  -16'sd100,  1'b0, '0, '0},
        '{ROW_ITEM,  '0,                     16'sd0,     1'b1, 16'sd100,    17'sd1000},
        '{ROW_ITEM,  '0,                     16'sd32767, 1'b1, 16'sd100,    -17'sd31767},
        // Narrow window, extreme measurements.
        '{ROW_WRITE, ppid_pkg::REG_OUT_MIN,  -16'sd500,  1'b0, '0, '0},
        '{ROW_WRITE, ppid_pkg::REG_OUT_MAX,  16'sd500,   1'b0, '0, '0},
        '{ROW_ITEM,  '0,                     16'sh8000,  1'b0, '0, '0},
        '{ROW_ITEM,  '0,                     16'sd32767, 1'b0, '0, '0},
        // Extreme gains and target: widest error and error step.
        '{ROW_WRITE, ppid_pkg::REG_GAIN_P,   16'sh8000,  1'b0, '0, '0},
        '{ROW_WRITE, ppid_pkg::REG_GAIN_I,   16'sd32767, 1'b0, '0, '0},
        '{ROW_WRITE, ppid_pkg::REG_GAIN_D,   16'sd32767, 1'b0, '0, '0},
        '{ROW_WRITE, ppid_pkg::REG_SETPOINT, 16'sh8000,  1'b0, '0, '0},
        '{ROW_ITEM,  '0,                     16'sd32767, 1'b0, '0, '0},
        '{ROW_ITEM,  '0,                     16'sh8000,  1'b0, '0, '0},
        '{ROW_ITEM,  '0,                     16'sd32767, 1'b0, '0, '0},
        // Unknown indexes: nothing may change.
        '{ROW_WRITE, REG_SPARE_6,            16'shFFFF,  1'b0, '0, '0},
        '{ROW_WRITE, REG_SPARE_7,            16'sh5A5A,  1'b0, '0, '0},
        '{ROW_ITEM,  '0,                     16'sd0,     1'b0, '0, '0},
        // Open the clamp again.
        '{ROW_WRITE, ppid_pkg::REG_OUT_MIN,  16'sh8000,  1'b0, '0, '0},
        '{ROW_WRITE, ppid_pkg::REG_OUT_MAX,  16'sd32767, 1'b0, '0, '0},
        '{ROW_ITEM,  '0,                     -16'sd1,    1'b0, '0, '0}
    };

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_write = 1'b0;
    logic [ppid_pkg::REG_INDEX_W-1:0]     cfg_index = '0;
    logic [ppid_pkg::DATA_W-1:0]          cfg_data = '0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic signed [ppid_pkg::DATA_W-1:0]   measurement = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic signed [ppid_pkg::DATA_W-1:0]   drive;
    logic signed [ppid_pkg::ERR_W-1:0]    current_error;

    // Shadow of the controller: register file plus loop state.
    ppid_pkg::cfg_t                       shadow_cfg;
    logic signed [INTEG_W-1:0]            integ_acc;
    logic signed [ppid_pkg::ERR_W-1:0]    last_err;

    ctl_out_t                   pending_ctl [$];
    int                         mismatches = 0;
    int                         idle_cycles = 0;

    positional_pid_controller_unit #(
        .INTEGRAL_WIDTH (INTEG_W)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .measurement   (measurement),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .drive         (drive),
        .current_error (current_error)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Advance the shadow loop by one tick and return drive and error.
    // Integral first (saturating), then the exact sum, floor shift, clamp.
    function automatic ctl_out_t pid_update(input logic signed [ppid_pkg::DATA_W-1:0] meas);
        ctl_out_t r;
        longint   err;
        longint   acc;
        longint   raw;
        longint   imax;
        longint   imin;
        imax = (longint'(1) <<< (INTEG_W - 1)) - 1;
        imin = -imax - 1;
        err = longint'($signed(shadow_cfg.setpoint)) - longint'(meas);
        acc = longint'(integ_acc) + err;
        if (acc > imax)
            acc = imax;
        if (acc < imin)
            acc = imin;
        integ_acc = acc[INTEG_W-1:0];
        raw = longint'($signed(shadow_cfg.gain_p)) * err
            + longint'($signed(shadow_cfg.gain_i)) * acc
            + longint'($signed(shadow_cfg.gain_d)) * (err - longint'(last_err));
        raw = raw >>> ppid_pkg::GAIN_FRAC_BITS;
        // Upper clamp first, lower clamp second: inverted limits give out_min.
        if (raw > longint'($signed(shadow_cfg.out_max)))
            raw = longint'($signed(shadow_cfg.out_max));
        if (raw < longint'($signed(shadow_cfg.out_min)))
            raw = longint'($signed(shadow_cfg.out_min));
        last_err = err[ppid_pkg::ERR_W-1:0];
        r.drive_val = raw[ppid_pkg::DATA_W-1:0];
        r.error_val = err[ppid_pkg::ERR_W-1:0];
        return r;
    endfunction

    // Gap length: mostly none or short, now and then long.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 60);
    endfunction

    // Register data: extremes and unity gain often, otherwise any word.
    function automatic logic [ppid_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3: return ppid_pkg::GAIN_P_RESET;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        if (mismatches < 10)
            $display("mismatch on %0s: expected %0d, actual %0d", what, want, got);
        mismatches++;
    endtask

    // Drop in_valid and hold until every expected result has left, then let
    // the pipeline settle before touching a register.
    task automatic drain_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_ctl.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [ppid_pkg::REG_INDEX_W-1:0] idx,
                             input logic [ppid_pkg::DATA_W-1:0] value);
        drain_pipeline();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            ppid_pkg::REG_GAIN_P: shadow_cfg.gain_p = value;
            ppid_pkg::REG_GAIN_I: shadow_cfg.gain_i = value;
            ppid_pkg::REG_GAIN_D: shadow_cfg.gain_d = value;
            ppid_pkg::REG_SETPOINT:
            begin
                // A new target clears the integral and loads the history.
                shadow_cfg.setpoint = value;
                integ_acc = '0;
                last_err = {value[ppid_pkg::DATA_W-1], value};
            end
            ppid_pkg::REG_OUT_MIN: shadow_cfg.out_min = value;
            ppid_pkg::REG_OUT_MAX: shadow_cfg.out_max = value;
            default: ;
        endcase
    endtask

    // Present one measurement after an optional gap and hold it until the
    // transfer happens; then queue what the result has to be. in_valid stays
    // high when the next item follows with no gap.
    task automatic send_measurement(input logic [ppid_pkg::DATA_W-1:0] meas, input int gap,
                                    input bit typed, input ctl_out_t typed_exp);
        ctl_out_t predicted;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        measurement <= meas;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // Advance the shadow state even when the row gives its own answer.
        predicted = pid_update(meas);
        pending_ctl.push_back(typed ? typed_exp : predicted);
    endtask

    // Rewrite a random subset of the registers; limits are usually ordered,
    // sometimes left inverted.
    task automatic shuffle_config();
        logic [ppid_pkg::DATA_W-1:0] lo;
        logic [ppid_pkg::DATA_W-1:0] hi;
        if ($urandom_range(0, 1))
            reg_write(ppid_pkg::REG_GAIN_P, pick_word());
        if ($urandom_range(0, 1))
            reg_write(ppid_pkg::REG_GAIN_I, pick_word());
        if ($urandom_range(0, 1))
            reg_write(ppid_pkg::REG_GAIN_D, pick_word());
        if ($urandom_range(0, 1))
            reg_write(ppid_pkg::REG_SETPOINT, pick_word());
        if ($urandom_range(0, 1))
        begin
            lo = pick_word();
            hi = pick_word();
            if ($urandom_range(0, 4) != 0 && $signed(lo) > $signed(hi))
                {lo, hi} = {hi, lo};
            reg_write(ppid_pkg::REG_OUT_MIN, lo);
            reg_write(ppid_pkg::REG_OUT_MAX, hi);
        end
        if ($urandom_range(0, 3) == 0)
            reg_write($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));
    endtask

    // Result checker: compare every output transfer against the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin : check_results
        ctl_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_ctl.size() == 0)
                flag_mismatch("unexpected result, drive", 0, int'(drive));
            else
            begin
                want = pending_ctl.pop_front();
                if (drive !== want.drive_val)
                    flag_mismatch("drive", int'(want.drive_val), int'(drive));
                if (current_error !== want.error_val)
                    flag_mismatch("current_error", int'(want.error_val),
                                  int'(current_error));
            end
        end
    end

    // Watchdog: count cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Receiver back-pressure: stall bursts of random length between runs of
    // acceptance, with occasional long runs free of stalls.
    initial
    begin : stall_gen
        int n;
        @(posedge rst_n);
        forever
        begin
            n = pause_len();
            if (n > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            if ($urandom_range(0, 19) == 0)
                repeat ($urandom_range(40, 150)) @(negedge clk);
            else
                repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    initial
    begin : stimulus
        dir_row_t    row;
        ctl_out_t    typed_exp;
        phase_kind_t kind;
        int          rand_items;
        int          phase;
        int          count;
        int          v;
        bit          no_gaps;
        logic [ppid_pkg::DATA_W-1:0] meas_word;

        shadow_cfg.gain_p   = ppid_pkg::GAIN_P_RESET;
        shadow_cfg.gain_i   = ppid_pkg::GAIN_I_RESET;
        shadow_cfg.gain_d   = ppid_pkg::GAIN_D_RESET;
        shadow_cfg.setpoint = ppid_pkg::SETPOINT_RESET;
        shadow_cfg.out_min  = ppid_pkg::OUT_MIN_RESET;
        shadow_cfg.out_max  = ppid_pkg::OUT_MAX_RESET;
        integ_acc = '0;
        last_err  = '0;

        // Hold reset, then release away from the rising edge.
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table: walk rows in order.
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = dir_tab[i];
            if (row.kind == ROW_WRITE)
                reg_write(row.idx, row.value);
            else
            begin
                typed_exp.drive_val = row.exp_drive;
                typed_exp.error_val = row.exp_err;
                send_measurement(row.value, pause_len(), row.typed, typed_exp);
            end
        end

        // Random phases: reconfigure while idle, then a burst of ticks.
        // Windup bursts push the integral hard to either side.
        rand_items = 0;
        phase = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            shuffle_config();
            if (phase == 2 || phase == 5 || $urandom_range(0, 9) == 0)
                kind = PH_WINDUP;
            else if ($urandom_range(0, 2) == 0)
                kind = PH_NOISE;
            else
                kind = PH_TRACK;
            if (kind == PH_WINDUP)
            begin
                if (phase == 5 || (phase != 2 && $urandom_range(0, 1)))
                    reg_write(ppid_pkg::REG_SETPOINT, 16'sh8000);
                else
                    reg_write(ppid_pkg::REG_SETPOINT, 16'sh7FFF);
                count = $urandom_range(160, 220);
            end
            else
                count = $urandom_range(15, 60);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < count && rand_items < RANDOM_ITEMS; k++)
            begin
                case (kind)
                    PH_NOISE:
                        meas_word = 16'($urandom);
                    PH_TRACK:
                    begin
                        // Hover around the target, as a settled loop would.
                        v = int'($signed(shadow_cfg.setpoint))
                            + int'($urandom_range(0, 512)) - 256;
                        if (v > 32767)
                            v = 32767;
                        if (v < -32768)
                            v = -32768;
                        meas_word = 16'(v);
                    end
                    default:
                    begin
                        // Measurement pinned at the far end from the target.
                        if ($signed(shadow_cfg.setpoint) < 0)
                            v = 32767 - int'($urandom_range(0, 15));
                        else
                            v = -32768 + int'($urandom_range(0, 15));
                        meas_word = 16'(v);
                    end
                endcase
                send_measurement(meas_word, no_gaps ? 0 : pause_len(), 1'b0, '0);
                rand_items++;
            end
            phase++;
        end

        // Drain, then give any stray result time to show up.
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_ctl.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES * 2) @(posedge clk);

        if (mismatches == 0 && pending_ctl.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
